### hdl/ptt_pkg.sv
package ptt_pkg;

   localparam int NUM_SLOTS_DEF  = 8;
   localparam int TIME_WIDTH_DEF = 32;
   localparam int MAX_RESULTS    = 8;
   localparam int FIELD_TIME_W   = 32;
   localparam int FIELD_SLOT_W   = 3;
   localparam int REQ_DATA_W     = 72;
   localparam int RSP_DATA_W     = 8;

   typedef enum logic {
      OP_TIME = 1'b0,
      OP_LOAD = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type                opcode;
      logic [FIELD_TIME_W-1:0]   now_ms;
      logic [FIELD_SLOT_W-1:0]   slot_index;
      logic [FIELD_TIME_W-1:0]   slot_delay;
      logic                      slot_enable;
      logic                      slot_repeat;
   } item_type;

endpackage

### hdl/ptt_front.sv
module ptt_front import ptt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output item_type              q_item,
   output logic                  q_valid,
   input  logic                  q_ready
);

   item_type   queue_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   item_type   item_in;
   logic       push;
   logic       pop;

   // unpack and classify the incoming item
   always_comb begin
      item_in.opcode      = req_tuser ? OP_LOAD : OP_TIME;
      item_in.now_ms      = req_tdata[31:0];
      item_in.slot_index  = req_tdata[34:32];
      item_in.slot_delay  = req_tdata[66:35];
      item_in.slot_enable = req_tdata[67];
      item_in.slot_repeat = req_tdata[68];
   end

   assign req_tready = (count_ff != 2'd2);
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### hdl/ptt_div.sv
module ptt_div import ptt_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_WIDTH-1:0] dividend,
   input  logic [TIME_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [TIME_WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(TIME_WIDTH + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [TIME_WIDTH-1:0] rem_ff;
   logic [TIME_WIDTH-1:0] dvd_ff;
   logic [TIME_WIDTH-1:0] dsr_ff;
   logic [TIME_WIDTH:0]   trial;
   logic [TIME_WIDTH:0]   diff;
   logic [TIME_WIDTH-1:0] rem_in;

   // restoring remainder, one bit a cycle
   always_comb begin
      trial  = {rem_ff, dvd_ff[TIME_WIDTH-1]};
      diff   = trial - {1'b0, dsr_ff};
      rem_in = (trial >= {1'b0, dsr_ff}) ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(TIME_WIDTH);
            rem_ff  <= '0;
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[TIME_WIDTH-2:0], 1'b0};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

### hdl/ptt_back.sv
module ptt_back import ptt_pkg::*; #(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  item_type              q_item,
   input  logic                  q_valid,
   output logic                  q_ready,
   output logic                  div_start,
   output logic [TIME_WIDTH-1:0] div_dividend,
   output logic [TIME_WIDTH-1:0] div_divisor,
   input  logic                  div_done,
   input  logic [TIME_WIDTH-1:0] div_rem,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_DIV,
      S_EMIT,
      S_FINAL
   } state_type;

   state_type             state_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic [NUM_SLOTS-1:0]  enabled_ff;
   logic [NUM_SLOTS-1:0]  repeat_ff;
   logic [NUM_SLOTS-1:0]  first_ff;
   logic [CNT_W-1:0]      fire_cnt_ff;
   logic                  pend_v_ff;
   logic [2:0]            pend_slot_ff;
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_slot_ff;
   logic                  rsp_last_ff;

   logic [TIME_WIDTH-1:0] period_mem [NUM_SLOTS];
   logic [TIME_WIDTH-1:0] ref_mem    [NUM_SLOTS];
   logic [TIME_WIDTH-1:0] rd_period_ff;
   logic [TIME_WIDTH-1:0] rd_ref_ff;

   logic                  load_ok;
   logic [SLOT_W-1:0]     load_slot;
   logic                  period_we;
   logic                  ref_we;
   logic [TIME_WIDTH-1:0] ref_wdata;
   logic [TIME_WIDTH-1:0] ref_cur;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  slot_on;
   logic                  hit;
   logic                  last_slot;
   logic                  out_free;
   logic [2:0]            slot_low;
   logic                  rsp_set;

   assign q_ready   = (state_ff == S_IDLE);
   assign load_ok   = ({4'd0, q_item.slot_index} < 7'(NUM_SLOTS));
   assign load_slot = SLOT_W'(q_item.slot_index);
   assign period_we = q_valid && q_ready && (q_item.opcode == OP_LOAD) && load_ok;
   assign slot_on   = enabled_ff[slot_ff];
   assign ref_cur   = first_ff[slot_ff] ? now_ff : rd_ref_ff;
   assign elapsed   = now_ff - ref_cur;
   assign hit       = (elapsed >= rd_period_ff);
   assign last_slot = (slot_ff == SLOT_W'(NUM_SLOTS - 1));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign slot_low  = 3'(slot_ff);
   assign rsp_set   = pend_v_ff && out_free &&
                      ((state_ff == S_EMIT && fire_cnt_ff != CNT_W'(MAX_RESULTS)) ||
                       state_ff == S_FINAL);

   assign div_start    = (state_ff == S_CHECK) && slot_on && hit && (rd_period_ff != '0);
   assign div_dividend = elapsed;
   assign div_divisor  = rd_period_ff;

   // reference: now on a first visit, else now minus elapsed mod period
   always_comb begin
      ref_we    = 1'b0;
      ref_wdata = now_ff;
      if (state_ff == S_CHECK && slot_on && first_ff[slot_ff]) begin
         ref_we = 1'b1;
      end else if (state_ff == S_DIV && div_done) begin
         ref_we    = 1'b1;
         ref_wdata = now_ff - div_rem;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 3){1'b0}}, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (period_we) begin
         period_mem[load_slot] <= TIME_WIDTH'(q_item.slot_delay);
      end
      if (ref_we) begin
         ref_mem[slot_ff] <= ref_wdata;
      end
      rd_period_ff <= period_mem[slot_ff];
      rd_ref_ff    <= ref_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         enabled_ff   <= '0;
         repeat_ff    <= '0;
         first_ff     <= '1;
         fire_cnt_ff  <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  if (q_item.opcode == OP_LOAD) begin
                     if (load_ok) begin
                        enabled_ff[load_slot] <= q_item.slot_enable;
                        repeat_ff[load_slot]  <= q_item.slot_repeat;
                        first_ff[load_slot]   <= 1'b1;
                     end
                  end else begin
                     now_ff      <= TIME_WIDTH'(q_item.now_ms);
                     slot_ff     <= '0;
                     fire_cnt_ff <= '0;
                     state_ff    <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (slot_on) begin
                  first_ff[slot_ff] <= 1'b0;
               end
               if (slot_on && hit) begin
                  if (!repeat_ff[slot_ff]) begin
                     enabled_ff[slot_ff] <= 1'b0;
                  end
                  state_ff <= div_start ? S_DIV : S_EMIT;
               end else if (last_slot) begin
                  state_ff <= S_FINAL;
               end else begin
                  slot_ff  <= slot_ff + SLOT_W'(1);
                  state_ff <= S_READ;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (fire_cnt_ff == CNT_W'(MAX_RESULTS) || !pend_v_ff || out_free) begin
                  if (fire_cnt_ff != CNT_W'(MAX_RESULTS)) begin
                     if (pend_v_ff) begin
                        rsp_slot_ff  <= pend_slot_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                     pend_v_ff    <= 1'b1;
                     pend_slot_ff <= slot_low;
                     fire_cnt_ff  <= fire_cnt_ff + CNT_W'(1);
                  end
                  if (last_slot) begin
                     state_ff <= S_FINAL;
                  end else begin
                     slot_ff  <= slot_ff + SLOT_W'(1);
                     state_ff <= S_READ;
                  end
               end
            end
            S_FINAL: begin
               if (!pend_v_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  rsp_slot_ff  <= pend_slot_ff;
                  rsp_last_ff  <= 1'b1;
                  pend_v_ff    <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

### hdl/periodic_task_timer_bank.sv
// load item: taken while the back end is idle, no result; one item in work at a time
// time item: scans every slot in turn; a fire whose delay is non-zero also runs the
// bit-serial remainder unit, and output back-pressure can stall the scan
// each result waits for the next fire or the scan end before it is sent
// synchronous reset: all slots disabled with first visit pending, queue and result emptied
module periodic_task_timer_bank import ptt_pkg::*; #(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms[31:0], slot_index[34:32], slot_delay[66:35], slot_enable[67], slot_repeat[68]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // fired_slot[2:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   item_type              q_item;
   logic                  q_valid;
   logic                  q_ready;
   logic                  div_start;
   logic [TIME_WIDTH-1:0] div_dividend;
   logic [TIME_WIDTH-1:0] div_divisor;
   logic                  div_done;
   logic [TIME_WIDTH-1:0] div_rem;

   ptt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_ready    (q_ready)
   );

   ptt_div #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   ptt_back #(
      .NUM_SLOTS  (NUM_SLOTS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_item       (q_item),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_rem      (div_rem),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

   a_div_no_early_done: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done)
      else $error("remainder unit finished straight after start");

   a_div_not_restarted: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_start)
      else $error("remainder unit started twice in a row");

   a_queue_holds: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid)
      else $error("queue lost an item while the back end was busy");

   a_rsp_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:3] == '0)
      else $error("result padding not zero");

endmodule
